// ----- sv/lru_kv_pkg.sv -----
// Shared types and constants for the LRU key/value cache.
package lru_kv_pkg;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam int CAP_BITS = 4;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd8;

    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctl_t;

endpackage

// ----- sv/lru_kv_mem.sv -----
// Key and value storage of the cache entries, one write and one registered read port.
module lru_kv_mem #(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3,
    parameter int KEY_BITS = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [IDX_W-1:0]      waddr,
    input  logic [KEY_BITS-1:0]   wkey,
    input  logic [VALUE_BITS-1:0] wval,
    input  logic [IDX_W-1:0]      raddr,
    output logic [KEY_BITS-1:0]   rkey,
    output logic [VALUE_BITS-1:0] rval
);

    logic [KEY_BITS-1:0]   key_mem [DEPTH];
    logic [VALUE_BITS-1:0] val_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr] <= wkey;
            val_mem[waddr] <= wval;
        end
        rkey <= key_mem[raddr];
        rval <= val_mem[raddr];
    end

endmodule

// ----- sv/lru_kv_scan.sv -----
// Shared compare unit that walks the entries one per cycle and collects the search results.
module lru_kv_scan #(
    parameter int IDX_W = 3,
    parameter int AGE_W = 3,
    parameter int KEY_BITS = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lru_kv_pkg::scan_ctl_t   ctl,
    input  logic [IDX_W-1:0]        idx,
    input  logic [KEY_BITS-1:0]     search_key,
    input  logic [KEY_BITS-1:0]     ent_key,
    input  logic [VALUE_BITS-1:0]   ent_val,
    input  logic                    ent_valid,
    input  logic [AGE_W-1:0]        ent_age,
    output logic                    hit,
    output logic [IDX_W-1:0]        match_idx,
    output logic [VALUE_BITS-1:0]   match_val,
    output logic [AGE_W-1:0]        match_age,
    output logic                    lru_found,
    output logic [IDX_W-1:0]        lru_idx,
    output logic [AGE_W-1:0]        lru_age,
    output logic [KEY_BITS-1:0]     lru_key,
    output logic                    free_found,
    output logic [IDX_W-1:0]        free_idx,
    output logic                    mru_found,
    output logic [KEY_BITS-1:0]     mru_key
);

    logic hit_reg;
    logic lru_found_reg;
    logic free_found_reg;
    logic mru_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [VALUE_BITS-1:0] match_val_reg;
    logic [AGE_W-1:0] match_age_reg;
    logic [IDX_W-1:0] lru_idx_reg;
    logic [AGE_W-1:0] lru_age_reg;
    logic [KEY_BITS-1:0] lru_key_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [KEY_BITS-1:0] mru_key_reg;

    logic take_match;
    logic take_lru;
    logic take_free;
    logic take_mru;

    always_comb
    begin
        take_match = ctl.sample && ent_valid && (ent_key == search_key) && !hit_reg;
        take_lru   = ctl.sample && ent_valid && (!lru_found_reg || (ent_age > lru_age_reg));
        take_free  = ctl.sample && !ent_valid && !free_found_reg;
        take_mru   = ctl.sample && ent_valid && (ent_age == '0) && !mru_found_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg        <= 1'b0;
            lru_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            mru_found_reg  <= 1'b0;
        end
        else if (ctl.clear)
        begin
            hit_reg        <= 1'b0;
            lru_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            mru_found_reg  <= 1'b0;
        end
        else
        begin
            if (take_match)
                hit_reg <= 1'b1;
            if (take_lru)
                lru_found_reg <= 1'b1;
            if (take_free)
                free_found_reg <= 1'b1;
            if (take_mru)
                mru_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_match)
        begin
            match_idx_reg <= idx;
            match_val_reg <= ent_val;
            match_age_reg <= ent_age;
        end
        if (take_lru)
        begin
            lru_idx_reg <= idx;
            lru_age_reg <= ent_age;
            lru_key_reg <= ent_key;
        end
        if (take_free)
            free_idx_reg <= idx;
        if (take_mru)
            mru_key_reg <= ent_key;
    end

    assign hit        = hit_reg;
    assign match_idx  = match_idx_reg;
    assign match_val  = match_val_reg;
    assign match_age  = match_age_reg;
    assign lru_found  = lru_found_reg;
    assign lru_idx    = lru_idx_reg;
    assign lru_age    = lru_age_reg;
    assign lru_key    = lru_key_reg;
    assign free_found = free_found_reg;
    assign free_idx   = free_idx_reg;
    assign mru_found  = mru_found_reg;
    assign mru_key    = mru_key_reg;

endmodule

// ----- sv/lru_key_value_cache_top.sv -----
// Top level of the LRU key/value cache: sequencer, recency state and output register.
// Each word passes from acceptance to its result through the key scan of each entry in turn
// through the shared compare unit, the last registered read, and the update, which also loads
// the output register; a new word is taken only in the idle state after the update of the last.
// A waiting result does not block a new input word; only the update step waits on it. Reset
// clears all entries, the ranks and the count, and sets capacity to 8.
module lru_key_value_cache_top #(
    parameter int DEPTH = 8,
    parameter int KEY_BITS = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cmd,
    input  logic [KEY_BITS-1:0]                 key,
    input  logic signed [VALUE_BITS-1:0]        value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic signed [VALUE_BITS-1:0]        read_value,
    output logic                                evicted,
    output logic [KEY_BITS-1:0]                 evicted_key,
    output logic                                mru_valid,
    output logic [KEY_BITS-1:0]                 mru_key,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lru_kv_pkg::CAP_BITS-1:0]     cfg_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AGE_W = IDX_W;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > lru_kv_pkg::CAP_BITS) ? CNT_W : lru_kv_pkg::CAP_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_UPDATE
    } state_t;

    state_t state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic sample_reg;
    logic cmd_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [lru_kv_pkg::CAP_BITS-1:0] capacity_reg;

    logic valid_reg [DEPTH];
    logic valid_next [DEPTH];
    logic [AGE_W-1:0] age_reg [DEPTH];
    logic [AGE_W-1:0] age_next [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic out_valid_reg;
    logic hit_out_reg;
    logic [VALUE_BITS-1:0] rv_out_reg;
    logic ev_out_reg;
    logic [KEY_BITS-1:0] evk_out_reg;
    logic mv_out_reg;
    logic [KEY_BITS-1:0] mk_out_reg;

    logic in_accept;
    logic out_free;
    logic update_go;
    lru_kv_pkg::scan_ctl_t scan_ctl;

    logic [KEY_BITS-1:0] mem_rkey;
    logic [VALUE_BITS-1:0] mem_rval;
    logic mem_we;
    logic [IDX_W-1:0] mem_waddr;

    logic s_hit;
    logic [IDX_W-1:0] s_match_idx;
    logic [VALUE_BITS-1:0] s_match_val;
    logic [AGE_W-1:0] s_match_age;
    logic s_lru_found;
    logic [IDX_W-1:0] s_lru_idx;
    logic [AGE_W-1:0] s_lru_age;
    logic [KEY_BITS-1:0] s_lru_key;
    logic s_free_found;
    logic [IDX_W-1:0] s_free_idx;
    logic s_mru_found;
    logic [KEY_BITS-1:0] s_mru_key;

    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] eff_cap;
    logic do_touch;
    logic [IDX_W-1:0] touch_idx;
    logic [AGE_W-1:0] touch_age;
    logic res_ev;
    logic [KEY_BITS-1:0] res_evk;
    logic [VALUE_BITS-1:0] res_rv;
    logic res_mv;
    logic [KEY_BITS-1:0] res_mk;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign update_go = (state_reg == S_UPDATE) && out_free;
    assign cfg_ready = 1'b1;

    assign scan_ctl.clear  = in_accept;
    assign scan_ctl.sample = sample_reg;

    lru_kv_mem #(
        .DEPTH(DEPTH),
        .IDX_W(IDX_W),
        .KEY_BITS(KEY_BITS),
        .VALUE_BITS(VALUE_BITS)
    ) u_mem (
        .clk(clk),
        .we(mem_we),
        .waddr(mem_waddr),
        .wkey(key_reg),
        .wval(val_reg),
        .raddr(idx_reg),
        .rkey(mem_rkey),
        .rval(mem_rval)
    );

    lru_kv_scan #(
        .IDX_W(IDX_W),
        .AGE_W(AGE_W),
        .KEY_BITS(KEY_BITS),
        .VALUE_BITS(VALUE_BITS)
    ) u_scan (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(scan_ctl),
        .idx(rd_idx_reg),
        .search_key(key_reg),
        .ent_key(mem_rkey),
        .ent_val(mem_rval),
        .ent_valid(valid_reg[rd_idx_reg]),
        .ent_age(age_reg[rd_idx_reg]),
        .hit(s_hit),
        .match_idx(s_match_idx),
        .match_val(s_match_val),
        .match_age(s_match_age),
        .lru_found(s_lru_found),
        .lru_idx(s_lru_idx),
        .lru_age(s_lru_age),
        .lru_key(s_lru_key),
        .free_found(s_free_found),
        .free_idx(s_free_idx),
        .mru_found(s_mru_found),
        .mru_key(s_mru_key)
    );

    // A capacity of zero acts as one, and one above DEPTH acts as DEPTH.
    always_comb
    begin
        cap_ext = CMP_W'(capacity_reg);
        priority if (cap_ext == '0)
            eff_cap = CMP_W'(1);
        else if (cap_ext > DEPTH_CMP)
            eff_cap = DEPTH_CMP;
        else
            eff_cap = cap_ext;
    end

    always_comb
    begin
        valid_next = valid_reg;
        age_next   = age_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_waddr  = s_match_idx;
        do_touch   = 1'b0;
        touch_idx  = s_match_idx;
        touch_age  = s_match_age;
        res_ev     = 1'b0;
        res_evk    = '0;
        res_rv     = '0;
        res_mv     = 1'b0;
        res_mk     = '0;

        if (cmd_reg == lru_kv_pkg::CMD_LOOKUP)
        begin
            if (s_hit)
            begin
                do_touch = 1'b1;
                res_rv   = s_match_val;
                res_mv   = 1'b1;
                res_mk   = key_reg;
            end
            else if (s_mru_found)
            begin
                res_mv = 1'b1;
                res_mk = s_mru_key;
            end
        end
        else
        begin
            res_mv = 1'b1;
            res_mk = key_reg;
            if (s_hit)
            begin
                mem_we   = 1'b1;
                do_touch = 1'b1;
            end
            else if (CMP_W'(count_reg) >= eff_cap)
            begin
                if (s_lru_found)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = s_lru_idx;
                    do_touch  = 1'b1;
                    touch_idx = s_lru_idx;
                    touch_age = s_lru_age;
                    res_ev    = 1'b1;
                    res_evk   = s_lru_key;
                end
            end
            else if (s_free_found)
            begin
                mem_we    = 1'b1;
                mem_waddr = s_free_idx;
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (valid_reg[i])
                        age_next[i] = age_reg[i] + AGE_W'(1);
                end
                valid_next[s_free_idx] = 1'b1;
                age_next[s_free_idx]   = '0;
                count_next = count_reg + CNT_W'(1);
            end
        end

        if (do_touch)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (valid_reg[i] && (IDX_W'(i) != touch_idx) && (age_reg[i] < touch_age))
                    age_next[i] = age_reg[i] + AGE_W'(1);
            end
            age_next[touch_idx] = '0;
        end

        if (!update_go)
        begin
            valid_next = valid_reg;
            age_next   = age_reg;
            count_next = count_reg;
            mem_we     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
                age_reg[i]   <= '0;
            end
            count_reg    <= '0;
            capacity_reg <= lru_kv_pkg::CAP_RESET;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
                capacity_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= cmd;
            key_reg <= key;
            val_reg <= value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            rd_idx_reg    <= '0;
            sample_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_out_reg   <= 1'b0;
            rv_out_reg    <= '0;
            ev_out_reg    <= 1'b0;
            evk_out_reg   <= '0;
            mv_out_reg    <= 1'b0;
            mk_out_reg    <= '0;
        end
        else
        begin
            sample_reg <= (state_reg == S_SCAN);
            rd_idx_reg <= idx_reg;

            if (out_valid_reg && !out_stall && !update_go)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (in_accept)
                        state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (idx_reg == LAST_IDX)
                        state_reg <= S_DRAIN;
                    else
                        idx_reg <= idx_reg + IDX_W'(1);
                end
                S_DRAIN:
                begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        hit_out_reg   <= s_hit;
                        rv_out_reg    <= res_rv;
                        ev_out_reg    <= res_ev;
                        evk_out_reg   <= res_evk;
                        mv_out_reg    <= res_mv;
                        mk_out_reg    <= res_mk;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_out_reg;
    assign read_value  = rv_out_reg;
    assign evicted     = ev_out_reg;
    assign evicted_key = evk_out_reg;
    assign mru_valid   = mv_out_reg;
    assign mru_key     = mk_out_reg;

endmodule

// ----- sv/lru_kv_checker.sv -----
// Port-level assertions for the LRU key/value cache and their bind to the top level.
module lru_kv_checker #(
    parameter int KEY_BITS = 32,
    parameter int VALUE_BITS = 32
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  hit,
    input logic [VALUE_BITS-1:0] read_value,
    input logic                  evicted,
    input logic [KEY_BITS-1:0]   evicted_key,
    input logic                  mru_valid,
    input logic [KEY_BITS-1:0]   mru_key
);

    // A stalled result word keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(read_value)
            && $stable(evicted) && $stable(evicted_key) && $stable(mru_key))
    else $error("stalled result word changed");

    // The block works on one word at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in progress");

    // A hit never evicts.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted))
    else $error("eviction reported together with a hit");

    // A miss reads nothing, and no eviction reports a key.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit || read_value == '0) && (evicted || evicted_key == '0))
    else $error("read value or evicted key without cause");

    // After a hit or an eviction the store cannot be empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (hit || evicted) |-> mru_valid)
    else $error("store reported empty after a hit or eviction");

endmodule

bind lru_key_value_cache_top lru_kv_checker #(
    .KEY_BITS(KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
) u_lru_kv_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit),
    .read_value(read_value),
    .evicted(evicted),
    .evicted_key(evicted_key),
    .mru_valid(mru_valid),
    .mru_key(mru_key)
);
